// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL core.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/atos_pkg.sv -----
// Shared types and constants of the trimmed order statistics core.
// No dependencies.
`default_nettype none

package atos_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int SCALE_W         = 16;
    localparam int UV_W            = 28;
    localparam int CFG_CNT_W       = 5;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int IN_TDATA_W      = 16;
    localparam int MAX_SAMPLES_DEF = 16;
    localparam int MIN_SAMPLES     = 5;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE        = 1'b1;

    localparam logic [CFG_CNT_W-1:0] SAMPLE_COUNT_RST = 5'd10;
    localparam logic [SCALE_W-1:0]   SCALE_RST        = 16'd806;

    // sorted positions of the trimmed statistics
    localparam int LO_POS   = 2;
    localparam int TRIM_TOP = 3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] mid;
        logic [SAMPLE_W-1:0] lo;
    } t_stats;

    // first member is the MSB: lo lands in the lowest bits
    typedef struct packed {
        logic [UV_W-1:0]     max_uv;
        logic [UV_W-1:0]     mid_uv;
        logic [UV_W-1:0]     min_uv;
        logic [SAMPLE_W-1:0] trimmed_max;
        logic [SAMPLE_W-1:0] middle;
        logic [SAMPLE_W-1:0] trimmed_min;
    } t_result;

    localparam int OUT_TDATA_W = $bits(t_result);

    typedef struct packed {
        logic                ins;    // insert x this cycle
        logic                shift;  // move every value one cell down
        logic [SAMPLE_W-1:0] x;      // sample being inserted
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/atos_cell.sv -----
// One cell of the insertion chain: holds one sorted sample.
// Depends on atos_pkg.
`default_nettype none

module atos_cell #(
    parameter int IDX = 0,
    parameter int LW  = 5
) (
    input  wire logic                          i_clk,
    input  wire atos_pkg::t_cell_ctl           i_ctl,
    input  wire logic [LW-1:0]                 i_count,
    input  wire logic [atos_pkg::SAMPLE_W-1:0] i_left_val,
    input  wire logic                          i_left_gt,
    input  wire logic [atos_pkg::SAMPLE_W-1:0] i_right_val,
    output logic      [atos_pkg::SAMPLE_W-1:0] o_val,
    output logic                               o_gt
);

    localparam logic [LW-1:0] IDX_V = LW'(IDX);

    logic [atos_pkg::SAMPLE_W-1:0] r_val;
    logic [atos_pkg::SAMPLE_W-1:0] n_val;
    logic                          w_occ;
    logic                          w_end;

    // first empty cell acts as +infinity
    always_comb begin
        w_occ = IDX_V < i_count;
        w_end = IDX_V == i_count;
        o_gt  = (w_occ && (r_val > i_ctl.x)) || w_end;
        n_val = r_val;
        if (i_ctl.ins && o_gt) begin
            n_val = i_left_gt ? i_left_val : i_ctl.x;
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

// ----- rtl/core/atos_scale.sv -----
// Output register stage: the three statistics and their microvolt products.
// Depends on atos_pkg.
`default_nettype none

module atos_scale (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire atos_pkg::t_stats             i_stats,
    input  wire logic [atos_pkg::SCALE_W-1:0] i_scale,
    output atos_pkg::t_result                 o_result
);

    localparam int UV_W = atos_pkg::UV_W;

    atos_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result.trimmed_min <= i_stats.lo;
            r_result.middle      <= i_stats.mid;
            r_result.trimmed_max <= i_stats.hi;
            r_result.min_uv      <= UV_W'(i_stats.lo)  * UV_W'(i_scale);
            r_result.mid_uv      <= UV_W'(i_stats.mid) * UV_W'(i_scale);
            r_result.max_uv      <= UV_W'(i_stats.hi)  * UV_W'(i_scale);
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/core/adc_burst_trimmed_order_stats_core.sv -----
// Trimmed order statistics core. Takes one sample request per cycle while collecting.
// After the last sample of a burst, the chain drains past cell 0 and the product step
// then loads the output register, so the result request turns valid and input reopens
// in the same cycle. The product step waits only while the previous result request is
// still pending. Sync active-low reset: burst empty, no result pending, 10 samples and
// 806 uV/count.
`default_nettype none

module adc_burst_trimmed_order_stats_core #(
    parameter int MAX_SAMPLES = atos_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config write port
    input  wire logic                             i_cfg_we,
    input  wire logic [atos_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [atos_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // sample stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [atos_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [11:0] sample
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [11:0] trimmed_min, [23:12] middle, [35:24] trimmed_max,
    // [63:36] min_uv, [91:64] mid_uv, [119:92] max_uv
    output logic      [atos_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

`include "assert_macros.svh"

    localparam int SW = atos_pkg::SAMPLE_W;
    localparam int LW = $clog2(MAX_SAMPLES + 1);
    // width wide enough for both the 5-bit register and the length range
    localparam int CW = (LW > atos_pkg::CFG_CNT_W) ? LW : atos_pkg::CFG_CNT_W;

    localparam logic [CW-1:0] MIN_LEN  = CW'(atos_pkg::MIN_SAMPLES);
    localparam logic [CW-1:0] MAX_LEN  = CW'(MAX_SAMPLES);
    localparam logic [LW-1:0] LO_POS   = LW'(atos_pkg::LO_POS);
    localparam logic [LW-1:0] TRIM_TOP = LW'(atos_pkg::TRIM_TOP);

    // control states
    localparam logic [1:0] ST_COLLECT = 2'd0;  // sorting incoming samples
    localparam logic [1:0] ST_DRAIN   = 2'd1;  // shifting chain past cell 0
    localparam logic [1:0] ST_MUL     = 2'd2;  // scaling, waits for a free output register

    // configuration
    logic [atos_pkg::CFG_CNT_W-1:0] r_sample_count;
    logic [atos_pkg::SCALE_W-1:0]   r_scale;

    // control
    logic [1:0]    r_state, n_state;
    logic [LW-1:0] r_count, n_count;   // samples in the chain
    logic [LW-1:0] r_len,   n_len;     // burst length latched at its end
    logic [LW-1:0] r_step,  n_step;    // drain position now in cell 0
    logic          r_out_valid, n_out_valid;  // result request pending

    // captured statistics
    atos_pkg::t_stats r_stats;

    atos_pkg::t_cell_ctl w_ctl;
    atos_pkg::t_result   w_result;

    logic [SW-1:0] w_val [MAX_SAMPLES];
    logic          w_gt  [MAX_SAMPLES];

    logic          w_in_acc;
    logic [CW-1:0] w_cnt_ext;
    logic [CW-1:0] w_burst_len;
    logic [LW-1:0] w_taken;
    logic          w_burst_end;
    logic [LW-1:0] w_mid_pos;
    logic [LW-1:0] w_hi_pos;
    logic          w_cap_lo, w_cap_mid, w_cap_hi;
    logic          w_load;

    //--------------------------------------------------------------------------
    // Configuration writes
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= atos_pkg::SAMPLE_COUNT_RST;
            r_scale        <= atos_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                atos_pkg::REG_SAMPLE_COUNT: begin
                    r_sample_count <= i_cfg_wdata[atos_pkg::CFG_CNT_W-1:0];
                end
                atos_pkg::REG_SCALE: begin
                    r_scale <= i_cfg_wdata[atos_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Burst control
    //--------------------------------------------------------------------------
    always_comb begin
        w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;

        // burst length: register clamped to MIN..MAX
        w_cnt_ext = CW'(r_sample_count);
        if (w_cnt_ext < MIN_LEN) begin
            w_burst_len = MIN_LEN;
        end else if (w_cnt_ext > MAX_LEN) begin
            w_burst_len = MAX_LEN;
        end else begin
            w_burst_len = w_cnt_ext;
        end

        // a lowered length mid-burst ends the burst on the next sample
        w_taken     = r_count + LW'(1);
        w_burst_end = CW'(w_taken) >= w_burst_len;

        // (L-4)/2+2 reduces to L/2 for L >= 4
        w_mid_pos = r_len >> 1;
        w_hi_pos  = r_len - TRIM_TOP;

        w_cap_lo  = (r_state == ST_DRAIN) && (r_step == LO_POS);
        w_cap_mid = (r_state == ST_DRAIN) && (r_step == w_mid_pos);
        w_cap_hi  = (r_state == ST_DRAIN) && (r_step == w_hi_pos);

        // output register is free when empty or being taken this cycle
        w_load = (r_state == ST_MUL) && (!r_out_valid || i_m_axis_tready);

        w_ctl.ins   = w_in_acc;
        w_ctl.shift = (r_state == ST_DRAIN) && !w_cap_hi;
        w_ctl.x     = i_s_axis_tdata[SW-1:0];

        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        n_state = r_state;
        n_count = r_count;
        n_len   = r_len;
        n_step  = r_step;
        case (r_state)
            ST_COLLECT: begin
                if (w_in_acc) begin
                    if (w_burst_end) begin
                        n_state = ST_DRAIN;
                        n_count = '0;
                        n_len   = w_taken;
                        n_step  = '0;
                    end else begin
                        n_count = w_taken;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_cap_hi) begin
                    n_state = ST_MUL;
                end else begin
                    n_step = r_step + LW'(1);
                end
            end
            ST_MUL: begin
                if (w_load) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_len       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_len       <= n_len;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // cell 0 holds the sorted entry at r_step while draining
    always_ff @(posedge i_clk) begin
        if (w_cap_lo) begin
            r_stats.lo <= w_val[0];
        end
        if (w_cap_mid) begin
            r_stats.mid <= w_val[0];
        end
        if (w_cap_hi) begin
            r_stats.hi <= w_val[0];
        end
    end

    //--------------------------------------------------------------------------
    // Insertion chain: ascending order from cell 0
    //--------------------------------------------------------------------------
    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        logic [SW-1:0] w_left_val;
        logic          w_left_gt;
        logic [SW-1:0] w_right_val;

        if (g == 0) begin : g_first
            assign w_left_val = w_ctl.x;
            assign w_left_gt  = 1'b0;
        end else begin : g_inner
            assign w_left_val = w_val[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == MAX_SAMPLES - 1) begin : g_last
            assign w_right_val = w_val[g];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        atos_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_left_val  (w_left_val),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g])
        );
    end

    //--------------------------------------------------------------------------
    // Scaling and output register
    //--------------------------------------------------------------------------
    atos_scale u_scale (
        .i_clk    (i_clk),
        .i_load   (w_load),
        .i_stats  (r_stats),
        .i_scale  (r_scale),
        .o_result (w_result)
    );

    assign o_s_axis_tready = (r_state == ST_COLLECT);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = w_result;

    //--------------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------------
    `ASSERT_NEVER(a_count_range, r_count >= LW'(MAX_SAMPLES), "count beyond chain depth")
    `ASSERT_CLK(a_end_drains, (w_in_acc && w_burst_end) |=> (r_state == ST_DRAIN), "no drain")
    `ASSERT_CLK(a_hold, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "pending result changed")
    `ASSERT_CLK(a_reopen, w_load |=> o_s_axis_tready, "input not reopened after product step")

endmodule

`default_nettype wire
